### rtl/cprq_pkg.sv
// Shared constants and types for the coalescing priority request queue.
`default_nettype none
package cprq_pkg;
    localparam int QUEUE_DEPTH = 64;
    localparam int CHUNK_BITS  = 16;
    localparam int SEQ_BITS    = 32;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    // chunk, kind, priority, lod, morph, sequence
    localparam int ENT_BITS    = CHUNK_BITS + 1 + 16 + 4 + 9 + SEQ_BITS;

    localparam logic [2:0] OP_ENQ   = 3'd0;
    localparam logic [2:0] OP_DEQ   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_DEMOT = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CHUNK_BITS-1:0] chunk;
        logic                  kind;
        logic [15:0]           prio;
        logic [3:0]            lod;
        logic [8:0]            morph;
        logic [SEQ_BITS-1:0]   seq;
    } t_entry;
endpackage
`default_nettype wire

### rtl/coalescing_priority_request_queue_unit.sv
// Top level: slot table in RAM, sequential scan controller.
`default_nettype none
// After a word is taken there is a read-setup step, in which the first slot
// address goes to the RAM. The scan then reads one slot per cycle through
// the single RAM read port, comparing key and rank. A final state (S_DONE)
// does the update/write-back and loads the output register. Valid bits are
// flip-flops cleared at reset, so no clearing pass is needed. A new word is
// taken no earlier than the edge at which the previous result leaves the
// output register, so a stalled result holds off the input.
module coalescing_priority_request_queue_unit import cprq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [15:0] i_chunk,
    input  wire logic        i_req_kind,
    input  wire logic [15:0] i_new_priority,
    input  wire logic [8:0]  i_demote_scale,
    input  wire logic [3:0]  i_snap_lod,
    input  wire logic [8:0]  i_snap_morph,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_chunk,
    output logic             o_out_kind,
    output logic [15:0]      o_out_priority,
    output logic [3:0]       o_out_lod,
    output logic [8:0]       o_out_morph,
    output logic [6:0]       o_pending_count
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;
    t_state r_state;

    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [2:0]  r_op;
    logic [CHUNK_BITS-1:0] r_chunk;
    logic        r_kind;
    logic [15:0] r_prio;
    logic [8:0]  r_scale;
    logic [3:0]  r_lod;
    logic [8:0]  r_morph;
    logic [IDX_BITS:0] r_raddr;   // read address counter, may reach depth
    logic [IDX_BITS:0] r_cidx;    // index of data now on rd port
    logic        r_cval;          // rd port data is a scanned slot
    logic        r_hit;
    logic [IDX_BITS-1:0] r_hidx;
    t_entry      r_hent;
    logic        r_free_ok;
    logic [IDX_BITS-1:0] r_free;
    logic [SEQ_BITS-1:0] r_nseq;
    logic [CNT_BITS-1:0] r_occ;

    t_entry w_rd, w_wd;
    logic   w_we;
    logic [IDX_BITS-1:0] w_waddr;

    cprq_ram #(.WIDTH(ENT_BITS), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wd),
        .i_raddr(r_raddr[IDX_BITS-1:0]), .o_rdata(w_rd)
    );

    logic w_key_op, w_slot_v, w_match, w_better;
    logic [IDX_BITS-1:0] w_ci;
    assign w_key_op = (r_op == OP_ENQ) || (r_op == OP_DEMOT) || (r_op == OP_QUERY);
    assign w_ci     = r_cidx[IDX_BITS-1:0];
    assign w_slot_v = r_cval && r_valid[w_ci];
    assign w_match  = w_slot_v && (w_rd.chunk == r_chunk) && (w_rd.kind == r_kind);
    always_comb begin
        if (w_rd.prio != r_hent.prio) w_better = w_rd.prio > r_hent.prio;
        else if (w_rd.kind != r_hent.kind) w_better = w_rd.kind;
        else w_better = w_rd.seq < r_hent.seq;
    end

    logic [24:0] w_prod;
    logic [8:0]  w_sc;
    assign w_sc   = (r_scale > 9'd256) ? 9'd256 : r_scale;
    assign w_prod = r_hent.prio * w_sc;

    logic w_scan_end;
    assign w_scan_end = r_cval && (r_cidx == QUEUE_DEPTH[IDX_BITS:0] - 1'b1);

    // write-back happens in the cycle after the scan finishes
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_hidx;
        w_wd    = r_hent;
        if (r_state == S_DONE && !o_valid) begin
            if (r_op == OP_ENQ) begin
                if (r_hit) begin
                    w_we = 1'b1;
                    if (r_prio > r_hent.prio) w_wd.prio = r_prio;
                    w_wd.lod = r_lod;
                    w_wd.morph = r_morph;
                end else if (r_free_ok) begin
                    w_we = 1'b1;
                    w_waddr = r_free;
                    w_wd = '{chunk: r_chunk, kind: r_kind, prio: r_prio,
                             lod: r_lod, morph: r_morph, seq: r_nseq + 1'b1};
                end
            end else if (r_op == OP_DEMOT && r_hit) begin
                w_we = 1'b1;
                w_wd.prio = w_prod[23:8];
            end
        end
    end

    // result status, whether an entry is returned, and the new occupancy
    logic [1:0]          w_status;
    logic                w_ret;
    logic [CNT_BITS-1:0] n_occ;
    always_comb begin
        w_status = ST_OK;
        w_ret    = 1'b0;
        n_occ    = r_occ;
        if (r_op == OP_ENQ && !r_hit) begin
            if (r_free_ok) begin
                w_ret = 1'b1;
                n_occ = r_occ + 1'b1;
            end else w_status = ST_FULL;
        end else if (!r_hit && r_op <= OP_QUERY) begin
            w_status = ST_NONE;
        end else if (r_op <= OP_QUERY) begin
            w_ret = 1'b1;
            if (r_op == OP_DEQ) n_occ = r_occ - 1'b1;
        end
    end

    assign o_stall = (r_state != S_IDLE) || (o_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_nseq  <= '0;
            r_occ   <= '0;
            o_valid <= 1'b0;
            r_cval  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_valid && !i_stall) o_valid <= 1'b0;
                    if (i_valid && !o_stall) begin
                        r_op    <= i_opcode;
                        r_chunk <= i_chunk[CHUNK_BITS-1:0];
                        r_kind  <= i_req_kind;
                        r_prio  <= i_new_priority;
                        r_scale <= i_demote_scale;
                        r_lod   <= i_snap_lod;
                        r_morph <= (i_snap_morph > 9'd256) ? 9'd256 : i_snap_morph;
                        r_raddr <= '0;
                        r_cval  <= 1'b0;
                        r_hit   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_raddr != QUEUE_DEPTH[IDX_BITS:0]) r_raddr <= r_raddr + 1'b1;
                    r_cidx <= r_raddr;
                    // drops to zero once the counter has reached the depth
                    r_cval <= (r_raddr != QUEUE_DEPTH[IDX_BITS:0]);
                    if (w_key_op) begin
                        if (w_match && !r_hit) begin
                            r_hit <= 1'b1; r_hidx <= w_ci; r_hent <= w_rd;
                        end
                    end else if (w_slot_v && (!r_hit || w_better)) begin
                        r_hit <= 1'b1; r_hidx <= w_ci; r_hent <= w_rd;
                    end
                    if (r_cval && !r_valid[w_ci] && !r_free_ok) begin
                        r_free_ok <= 1'b1; r_free <= w_ci;
                    end
                    if (w_scan_end) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    o_valid <= 1'b1;
                    o_status <= w_status;
                    r_occ <= n_occ;
                    o_pending_count <= 7'(n_occ);
                    o_out_chunk    <= w_ret ? 16'(w_wd.chunk) : 16'd0;
                    o_out_kind     <= w_ret ? w_wd.kind : 1'b0;
                    o_out_priority <= w_ret ? w_wd.prio : 16'd0;
                    o_out_lod      <= w_ret ? w_wd.lod : 4'd0;
                    o_out_morph    <= w_ret ? w_wd.morph : 9'd0;
                    if (r_op == OP_ENQ && !r_hit && r_free_ok) begin
                        r_valid[r_free] <= 1'b1;
                        r_nseq <= r_nseq + 1'b1;
                    end else if (r_op == OP_DEQ && r_hit) begin
                        r_valid[r_hidx] <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/cprq_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/cprq_checker.sv
// Port-level checker for the queue unit, bound to the top level.
`default_nettype none
module cprq_checker import cprq_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [15:0] o_out_priority,
    input wire logic [6:0]  o_pending_count
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)) else $error("word dropped");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pending_count <= QUEUE_DEPTH) else $error("count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_pending_count == QUEUE_DEPTH)
        else $error("full with room");
    a_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_out_priority == 16'd0)
        else $error("fields not cleared");
    // a taken word starts a scan, so the input is held off next cycle
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("no scan after word");
endmodule

bind coalescing_priority_request_queue_unit cprq_checker u_chk (.*);
`default_nettype wire
